FILE: hw/rtl/iir_direct_form_two_filter_defines.svh
// Assertion helpers shared by the filter RTL.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef IIR_DIRECT_FORM_TWO_FILTER_DEFINES_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_DEFINES_SVH

// Same-cycle implication
`define IIR_DFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IIR_DFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/iir_dft_pkg.sv
package iir_dft_pkg;

  // Filter order: number of taps including the current internal value (2..4)
  localparam int TAPS        = 4;
  localparam int DELAY_DEPTH = 3;
  localparam int STEP_W      = $clog2(TAPS);
  localparam int DLY_IDX_W   = $clog2(DELAY_DEPTH);

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int W_W       = 24;
  localparam int PROD_W    = COEF_W + W_W;
  localparam int ACC_W     = 44;
  localparam int FRAC_BITS = 14;
  localparam int RND_W     = ACC_W - FRAC_BITS;

  localparam logic signed [COEF_W-1:0] ONE_Q14 = COEF_W'(1 << FRAC_BITS);
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FB1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FF1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FF2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FF3 = 3'd6;

  // Coefficient bank; entry k-1 of fb/ff belongs to delay element k-1
  typedef struct packed {
    logic [DELAY_DEPTH-1:0][COEF_W-1:0] fb;
    logic [COEF_W-1:0]                  ff0;
    logic [DELAY_DEPTH-1:0][COEF_W-1:0] ff;
  } coef_bank_t;

  // One multiply-accumulate operation
  typedef struct packed {
    logic en;    // operation valid
    logic load;  // start a new sum with this product
    logic neg;   // subtract the product
    logic last;  // final product of the sum
  } mac_ctl_t;

endpackage

FILE: hw/rtl/iir_direct_form_two_filter.sv
// Direct form II IIR filter, one shared 16x24 multiply-accumulate unit.
// Per item: sample and feedback taps go through the MAC, then the forward taps, then
//   forward tap 0 once the internal value is known, then the output step. A new item
//   is taken only after the last result is issued, so a stalled result delays it.
// Reset (rst_n low, synchronous): coefficients to defaults (forward_coef_0 =
//   1.0, others 0), delay line cleared, sequencer idle, no result pending.
`include "iir_direct_form_two_filter_defines.svh"

module iir_direct_form_two_filter
  import iir_dft_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FB   = 6'b000010,
    S_FF   = 6'b000100,
    S_F0   = 6'b001000,
    S_Y    = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [STEP_W-1:0]           cnt_r, cnt_nxt;
  logic [DLY_IDX_W-1:0]        k_idx;
  logic signed [W_W-1:0]       dly_r [DELAY_DEPTH];
  logic signed [W_W-1:0]       w_r;
  logic                        w_vld_r;
  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_sample_r;

  coef_bank_t                  coefs;
  mac_ctl_t                    mac_ctl;
  logic signed [COEF_W-1:0]    mac_coef;
  logic signed [W_W-1:0]       mac_data;
  logic signed [ACC_W-1:0]     mac_acc;
  logic                        mac_done;

  logic                        in_acc;
  logic                        out_free;
  logic                        step_last;
  logic [ACC_W-1:0]            rnd_sum;
  logic signed [RND_W-1:0]     rnd_q;

  // Saturate the rounded sum to the internal-value range
  function automatic logic signed [W_W-1:0] sat_w(input logic signed [RND_W-1:0] v);
    if (&v[RND_W-1:W_W-1] || ~|v[RND_W-1:W_W-1]) begin
      return v[W_W-1:0];
    end
    return {v[RND_W-1], {(W_W-1){~v[RND_W-1]}}};
  endfunction

  // Saturate the rounded sum to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_o(input logic signed [RND_W-1:0] v);
    if (&v[RND_W-1:SAMPLE_W-1] || ~|v[RND_W-1:SAMPLE_W-1]) begin
      return v[SAMPLE_W-1:0];
    end
    return {v[RND_W-1], {(SAMPLE_W-1){~v[RND_W-1]}}};
  endfunction

  iir_dft_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  iir_dft_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (mac_coef),
    .data  (mac_data),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign step_last = (cnt_r == STEP_W'(TAPS - 1));
  assign k_idx     = DLY_IDX_W'(cnt_r - 1'b1);

  // round half up: floor((acc + 2^13) / 2^14)
  assign rnd_sum = mac_acc + HALF_LSB;
  assign rnd_q   = rnd_sum[ACC_W-1:FRAC_BITS];

  // MAC operation issue
  always_comb begin
    mac_ctl  = '0;
    mac_coef = '0;
    mac_data = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // start with the sample scaled to Q14
          mac_ctl.en   = 1'b1;
          mac_ctl.load = 1'b1;
          mac_coef     = ONE_Q14;
          mac_data     = {{(W_W-SAMPLE_W){in_sample_in[SAMPLE_W-1]}}, in_sample_in};
        end
      end
      S_FB: begin
        mac_ctl.en   = 1'b1;
        mac_ctl.neg  = 1'b1;
        mac_ctl.last = step_last;
        mac_coef     = coefs.fb[k_idx];
        mac_data     = dly_r[k_idx];
      end
      S_FF: begin
        mac_ctl.en   = 1'b1;
        mac_ctl.load = (cnt_r == STEP_W'(1));
        mac_coef     = coefs.ff[k_idx];
        mac_data     = dly_r[k_idx];
      end
      S_F0: begin
        // current internal value goes last, once it is known
        if (w_vld_r) begin
          mac_ctl.en   = 1'b1;
          mac_ctl.last = 1'b1;
          mac_coef     = coefs.ff0;
          mac_data     = w_r;
        end
      end
      S_Y, S_OUT: ;
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_FB;
          cnt_nxt   = STEP_W'(1);
        end
      end
      S_FB: begin
        if (step_last) begin
          state_nxt = S_FF;
          cnt_nxt   = STEP_W'(1);
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FF: begin
        if (step_last) begin
          state_nxt = S_F0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_F0: if (w_vld_r) state_nxt = S_Y;
      S_Y:  if (mac_done) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Internal value: first finished sum of the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else if (mac_done && !w_vld_r) begin
      w_vld_r <= 1'b1;
    end else if (state_r == S_OUT && out_free) begin
      w_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_done && !w_vld_r) begin
      w_r <= sat_w(rnd_q);
    end
  end

  // Delay line shifts once per item as the result is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        dly_r[i] <= '0;
      end
    end else if (state_r == S_OUT && out_free) begin
      dly_r[0] <= w_r;
      for (int i = 1; i < DELAY_DEPTH; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_sample_r <= sat_o(rnd_q);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Checks
  `IIR_DFT_ASSERT_IMP(a_out_from_seq, $rose(out_valid_r), $past(state_r) == S_OUT,
                      "result without sequencer output step")
  `IIR_DFT_ASSERT_IMP(a_w_before_ff0, mac_ctl.en && mac_ctl.last && state_r == S_F0,
                      w_vld_r, "forward tap 0 issued before internal value")
  `IIR_DFT_ASSERT_IMP(a_fb_done_phase, mac_done && !w_vld_r,
                      state_r == S_FF || state_r == S_F0, "feedback sum finished out of phase")
  `IIR_DFT_ASSERT_NXT(a_dly_hold, state_r != S_OUT, $stable(dly_r[0]),
                      "delay line moved outside output step")

endmodule

FILE: hw/rtl/iir_dft_regs.sv
module iir_dft_regs
  import iir_dft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output coef_bank_t           coefs
);

  coef_bank_t bank_r;

  // always ready; writes beyond the map are dropped
  assign cfg_ready = 1'b1;
  assign coefs     = bank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // feedback taps 0, forward tap 0 at 1.0, other forward taps 0
      bank_r <= {{(DELAY_DEPTH*COEF_W){1'b0}}, ONE_Q14, {(DELAY_DEPTH*COEF_W){1'b0}}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FB1: bank_r.fb[0] <= cfg_data;
        REG_FB2: bank_r.fb[1] <= cfg_data;
        REG_FB3: bank_r.fb[2] <= cfg_data;
        REG_FF0: bank_r.ff0   <= cfg_data;
        REG_FF1: bank_r.ff[0] <= cfg_data;
        REG_FF2: bank_r.ff[1] <= cfg_data;
        REG_FF3: bank_r.ff[2] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/iir_dft_mac.sv
module iir_dft_mac
  import iir_dft_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [W_W-1:0]    data,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     done
);

  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  base;
  logic                     done_r;

  // stage 1: registered product
  always_ff @(posedge clk) begin
    prod_r <= coef * data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl;
      done_r <= ctl_r.en && ctl_r.last;
    end
  end

  // stage 2: accumulate or restart
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign base     = ctl_r.load ? '0 : acc_r;
  assign acc_nxt  = ctl_r.neg ? base - prod_ext : base + prod_ext;

  always_ff @(posedge clk) begin
    if (ctl_r.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

FILE: bench/iir_direct_form_two_filter_tb.sv
`timescale 1ns / 100ps

module iir_direct_form_two_filter_tb;
  import iir_dft_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 8;
  // Extra wait after the last result, before touching registers
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_PHASE_ITEMS = 105;

  // Index past the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef enum int {COEF_STABLE, COEF_FULL, COEF_EXTREME} coef_profile_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // Filter shadow state: register file in Q2.14 and past internal values
  logic signed [COEF_W-1:0] coef_q14 [7];
  logic signed [W_W-1:0] past_w [DELAY_DEPTH];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;
  int cycles = 0;

  iir_direct_form_two_filter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Round half up from Q14 to integer
  function automatic longint round_q14(input longint acc);
    return (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One sample through the shadow filter; updates the shadow delay line
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint w;
    longint y;
    int k;
    acc = longint'(x) <<< FRAC_BITS;
    for (k = 1; k < TAPS && k <= DELAY_DEPTH; k++) begin
      acc -= longint'(coef_q14[REG_FB1 + k - 1]) * longint'(past_w[k-1]);
    end
    w = clamp(round_q14(acc), -(longint'(1) <<< (W_W - 1)),
              (longint'(1) <<< (W_W - 1)) - 1);
    acc = longint'(coef_q14[REG_FF0]) * w;
    for (k = 1; k < TAPS && k <= DELAY_DEPTH; k++) begin
      acc += longint'(coef_q14[REG_FF0 + k]) * longint'(past_w[k-1]);
    end
    y = clamp(round_q14(acc), -32768, 32767);
    // Every sample shifts the whole delay line
    for (k = DELAY_DEPTH - 1; k > 0; k--) begin
      past_w[k] = past_w[k-1];
    end
    past_w[0] = W_W'(w);
    return SAMPLE_W'(y);
  endfunction

  // Result side: random stall and compare against the oldest expectation
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: no result expected, actual %0d", out_sample_out);
        failures++;
      end else begin
        logic signed [SAMPLE_W-1:0] want;
        want = expected_samples.pop_front();
        if (out_sample_out !== want) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want, out_sample_out);
          failures++;
        end
      end
    end
  end

  // Send one sample; in_valid stays high afterwards unless idling follows
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(filter_sample(s));
  endtask

  // Stop sending and let every pending result come out
  task automatic wait_filter_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it once done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_FF3) coef_q14[idx] = val;
  endtask

  task automatic program_filter(input logic [COEF_W-1:0] fb1, fb2, fb3,
                                input logic [COEF_W-1:0] ff0, ff1, ff2, ff3);
    wait_filter_idle();
    write_reg(REG_FB1, fb1);
    write_reg(REG_FB2, fb2);
    write_reg(REG_FB3, fb3);
    write_reg(REG_FF0, ff0);
    write_reg(REG_FF1, ff1);
    write_reg(REG_FF2, ff2);
    write_reg(REG_FF3, ff3);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] random_coef(input coef_profile_t profile,
                                                    input bit feedback);
    case (profile)
      // Feedback within +-0.25 each keeps the loop stable
      COEF_STABLE: begin
        if (feedback) return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
        return COEF_W'($urandom);
      end
      COEF_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return ONE_Q14;
        endcase
      end
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Default registers: forward_coef_0 = 1.0, output follows input exactly
  task automatic test_reset_defaults();
    send_sample(16'sh0000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(-16'sh0001);
  endtask

  // Gain 0.5 on odd samples lands on half steps; also a write past the map
  task automatic test_rounding();
    program_filter(16'h0000, 16'h0000, 16'h0000, 16'h2000, 16'h0000, 16'h0000, 16'h0000);
    write_reg(REG_NONE, 16'h7FFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_sample(16'sh0001);
    send_sample(-16'sh0001);
    send_sample(16'sh0003);
    send_sample(-16'sh0003);
  endtask

  // Feedback -2.0, then just under +2.0, makes the internal value run into both rails
  task automatic test_saturation();
    int i;
    program_filter(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    for (i = 0; i < 5; i++) send_sample(16'sh7FFF);
    for (i = 0; i < 5; i++) send_sample(16'sh8000);
    program_filter(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    for (i = 0; i < 2; i++) send_sample(16'sh7FFF);
    for (i = 0; i < 2; i++) send_sample(16'sh8000);
  endtask

  task automatic test_random_filtering(input int n, input int send_pct, input int recv_pct,
                                       input coef_profile_t profile);
    int i;
    program_filter(random_coef(profile, 1), random_coef(profile, 1), random_coef(profile, 1),
                   random_coef(profile, 0), random_coef(profile, 0),
                   random_coef(profile, 0), random_coef(profile, 0));
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n; i++) send_sample(random_sample());
    wait_filter_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    int i;
    for (i = 0; i < 7; i++) coef_q14[i] = '0;
    coef_q14[REG_FF0] = ONE_Q14;
    for (i = 0; i < DELAY_DEPTH; i++) past_w[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_rounding();
    test_saturation();

    test_random_filtering(RANDOM_PHASE_ITEMS, 0, 0, COEF_STABLE);
    test_random_filtering(RANDOM_PHASE_ITEMS, 82, 0, COEF_STABLE);
    test_random_filtering(RANDOM_PHASE_ITEMS, 0, 82, COEF_FULL);
    test_random_filtering(RANDOM_PHASE_ITEMS, 19, 19, COEF_EXTREME);
    test_random_filtering(RANDOM_PHASE_ITEMS, 0, 0, COEF_FULL);
    test_random_filtering(RANDOM_PHASE_ITEMS, 82, 0, COEF_EXTREME);
    test_random_filtering(RANDOM_PHASE_ITEMS, 0, 82, COEF_STABLE);
    test_random_filtering(RANDOM_PHASE_ITEMS, 19, 19, COEF_STABLE);

    wait_filter_idle();
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
